FILE: sv/uart_8n1_transceiver_3x_defines.svh
// ============================================================================
// UART 8N1 transceiver assertion macros
// Shared concurrent assertion forms for the transceiver RTL.
// ============================================================================
`ifndef UART_8N1_TRANSCEIVER_3X_DEFINES_SVH
`define UART_8N1_TRANSCEIVER_3X_DEFINES_SVH

// same-cycle implication, disabled in reset
`define U8T3_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("u8t3 same-cycle check failed");

// next-cycle implication, disabled in reset
`define U8T3_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("u8t3 next-cycle check failed");

`endif

FILE: sv/u8t3_pkg.sv
// ============================================================================
// UART 8N1 transceiver package
// Shared constants, state codes and result types.
// ============================================================================
package u8t3_pkg;

    localparam logic [1:0] TICKS_PER_BIT = 2'd3;
    localparam logic [1:0] SAMPLE_TICK   = 2'd2;
    localparam logic [3:0] DATA_BITS     = 4'd8;

    localparam logic [1:0] RX_IDLE  = 2'd0;
    localparam logic [1:0] RX_CHECK = 2'd1;
    localparam logic [1:0] RX_DATA  = 2'd2;

    localparam logic [3:0] TX_PHASE_START = 4'd0;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       false_start;
    } t_rx_res;

    typedef struct packed {
        logic level;
        logic busy;
        logic rejected;
    } t_tx_res;

endpackage

FILE: sv/u8t3_in_if.sv
// ============================================================================
// UART tick request channel
// Valid/ready channel carrying one oversampling tick request.
// ============================================================================
interface u8t3_in_if;
    logic       valid;
    logic       ready;
    logic       rx_level;
    logic       tx_start;
    logic [7:0] tx_data;

    modport source (output valid, output rx_level, output tx_start, output tx_data,
                    input ready);
    modport sink (input valid, input rx_level, input tx_start, input tx_data,
                  output ready);
endinterface

FILE: sv/u8t3_out_if.sv
// ============================================================================
// UART tick result channel
// Valid/ready channel carrying the line and status result of one tick.
// ============================================================================
interface u8t3_out_if;
    logic       valid;
    logic       ready;
    logic       tx_level;
    logic       tx_busy;
    logic       tx_rejected;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic       rx_false_start;

    modport source (output valid, output tx_level, output tx_busy, output tx_rejected,
                    output rx_valid, output rx_data, output rx_false_start,
                    input ready);
    modport sink (input valid, input tx_level, input tx_busy, input tx_rejected,
                  input rx_valid, input rx_data, input rx_false_start,
                  output ready);
endinterface

FILE: sv/uart_8n1_transceiver_3x.sv
// ============================================================================
// UART 8N1 transceiver, three ticks per bit
// One full-duplex channel; each request is one oversampling tick.
// ============================================================================
// Usage:
//   i_in carries one tick per request: the sampled receive level, a transmit
//   start flag and the byte to send. o_out returns exactly one result per
//   request: transmit line level and busy flag after the tick, a rejected
//   flag for a start while busy, and the receive byte strobe, byte and
//   false-start flag.
//   The result is registered: a request accepted at one edge shows its result
//   at o_out from the next cycle. While results are taken, throughput is one tick
//   per cycle, set by the single result register behind the rx and tx logic.
//   Reset puts the receiver in idle with the line seen high, the transmitter
//   idle with the line high, and drops any pending result.
//   When the result is not taken, the result register holds it and i_in
//   stalls; a new request is taken in the same cycle the result is taken.
// ============================================================================
`include "uart_8n1_transceiver_3x_defines.svh"

module uart_8n1_transceiver_3x
    import u8t3_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    u8t3_in_if.sink    i_in,
    u8t3_out_if.source o_out
);

    logic    w_step;
    t_rx_res w_rx;
    t_tx_res w_tx;
    logic    r_valid;
    t_rx_res r_rx;
    t_tx_res r_tx;

    assign i_in.ready = !r_valid || o_out.ready;
    assign w_step     = i_in.valid && i_in.ready;

    u8t3_rx u_rx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_level (i_in.rx_level),
        .o_res   (w_rx)
    );

    u8t3_tx u_tx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_start (i_in.tx_start),
        .i_data  (i_in.tx_data),
        .o_res   (w_tx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_step) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_rx <= w_rx;
            r_tx <= w_tx;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.tx_level       = r_tx.level;
    assign o_out.tx_busy        = r_tx.busy;
    assign o_out.tx_rejected    = r_tx.rejected;
    assign o_out.rx_valid       = r_rx.valid;
    assign o_out.rx_data        = r_rx.data;
    assign o_out.rx_false_start = r_rx.false_start;

    `U8T3_ASSERT_NEXT(a_accept_gives_result, i_clk, i_rst_n, w_step, o_out.valid)
    `U8T3_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !o_out.valid, i_in.ready)
    `U8T3_ASSERT_NOW(a_rx_one_event, i_clk, i_rst_n, o_out.valid,
        !(o_out.rx_valid && o_out.rx_false_start))
    `U8T3_ASSERT_NOW(a_rx_data_zero, i_clk, i_rst_n, o_out.valid && !o_out.rx_valid,
        o_out.rx_data == 8'd0)
    `U8T3_ASSERT_NOW(a_tx_idle_high, i_clk, i_rst_n, o_out.valid && !o_out.tx_busy,
        o_out.tx_level)

endmodule

FILE: sv/u8t3_rx.sv
// ============================================================================
// UART receiver
// Start detect, start check and LSB-first data sampling at three ticks per bit.
// ============================================================================
module u8t3_rx
    import u8t3_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  logic    i_level,
    output t_rx_res o_res
);

    logic [1:0] r_mode, n_mode;
    logic [7:0] r_shift, n_shift;
    logic [3:0] r_idx, n_idx;
    logic [1:0] r_tc, n_tc;
    logic       r_last, n_last;

    always_comb begin
        n_mode  = r_mode;
        n_shift = r_shift;
        n_idx   = r_idx;
        n_tc    = r_tc;
        n_last  = i_level;
        o_res   = '0;
        unique case (r_mode)
            RX_CHECK: begin
                n_tc = r_tc + 2'd1;
                if (n_tc == SAMPLE_TICK) begin
                    if (i_level) begin
                        n_mode            = RX_IDLE;
                        o_res.false_start = 1'b1;
                    end else begin
                        n_mode  = RX_DATA;
                        n_shift = '0;
                        n_idx   = '0;
                        n_tc    = '0;
                    end
                end
            end
            RX_DATA: begin
                n_tc = r_tc + 2'd1;
                if (n_tc == SAMPLE_TICK) begin
                    if (r_idx < DATA_BITS) begin
                        if (i_level) begin
                            n_shift[r_idx[2:0]] = 1'b1;
                        end
                        n_idx = r_idx + 4'd1;
                    end else begin
                        o_res.valid = 1'b1;
                        o_res.data  = r_shift;
                        n_mode      = RX_IDLE;
                    end
                end else if (n_tc == TICKS_PER_BIT) begin
                    n_tc = '0;
                end
            end
            default: begin
                n_mode = RX_IDLE;
                if (r_last && !i_level) begin
                    n_mode = RX_CHECK;
                    n_tc   = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= RX_IDLE;
            r_shift <= '0;
            r_idx   <= '0;
            r_tc    <= '0;
            r_last  <= 1'b1;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_shift <= n_shift;
            r_idx   <= n_idx;
            r_tc    <= n_tc;
            r_last  <= n_last;
        end
    end

endmodule

FILE: sv/u8t3_tx.sv
// ============================================================================
// UART transmitter
// Loads a byte on request and sends start, D0-D7 and stop at three ticks per bit.
// ============================================================================
module u8t3_tx
    import u8t3_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic       i_start,
    input  logic [7:0] i_data,
    output t_tx_res    o_res
);

    logic [7:0] r_shift, n_shift;
    logic       r_active, n_active;
    logic [3:0] r_phase, n_phase;
    logic [1:0] r_tc, n_tc;
    logic       r_line, n_line;
    logic [3:0] w_bit;

    assign w_bit = r_phase - 4'd1;

    always_comb begin
        n_shift  = r_shift;
        n_active = r_active;
        n_phase  = r_phase;
        n_tc     = r_tc;
        n_line   = r_line;
        o_res    = '0;
        if (i_start) begin
            if (r_active) begin
                o_res.rejected = 1'b1;
            end else begin
                n_shift  = i_data;
                n_active = 1'b1;
                n_phase  = TX_PHASE_START;
                n_tc     = '0;
            end
        end
        if (n_active) begin
            n_tc = n_tc + 2'd1;
            if (n_tc == TICKS_PER_BIT) begin
                n_tc = '0;
                priority if (n_phase == TX_PHASE_START) begin
                    n_line  = 1'b0;
                    n_phase = 4'd1;
                end else if (n_phase <= DATA_BITS) begin
                    n_line  = n_shift[w_bit[2:0]];
                    n_phase = n_phase + 4'd1;
                end else begin
                    n_line   = 1'b1;
                    n_active = 1'b0;
                end
            end
        end
        o_res.level = n_line;
        o_res.busy  = n_active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift  <= '0;
            r_active <= 1'b0;
            r_phase  <= TX_PHASE_START;
            r_tc     <= '0;
            r_line   <= 1'b1;
        end else if (i_step) begin
            r_shift  <= n_shift;
            r_active <= n_active;
            r_phase  <= n_phase;
            r_tc     <= n_tc;
            r_line   <= n_line;
        end
    end

endmodule

FILE: sim/tb_uart_8n1_transceiver_3x.sv
`timescale 1ns / 1ps
// ============================================================================
// Testbench for the 8N1 UART transceiver, three ticks per bit
// Sends oversampling tick requests over the valid/ready channel with random
// gaps and result stalls. A cycle model of the receiver and transmitter
// predicts the result of every tick, and each field is compared in order.
// ============================================================================
module tb_uart_8n1_transceiver_3x;
    import u8t3_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int FRAME_TICKS  = (int'(DATA_BITS) + 2) * int'(TICKS_PER_BIT);
    localparam int RANDOM_TICKS = 1320;

    typedef struct packed {
        t_tx_res tx;
        t_rx_res rx;
    } t_tick_res;

    logic i_clk = 1'b0;
    logic i_rst_n;

    u8t3_in_if  tick_ch ();
    u8t3_out_if res_ch ();

    uart_8n1_transceiver_3x DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tick_ch),
        .o_out   (res_ch)
    );

    logic [1:0] rx_phase      = RX_IDLE;
    logic [7:0] rx_byte       = '0;
    logic [3:0] rx_bits_seen  = '0;
    logic [1:0] rx_ticks      = '0;
    logic       rx_prev_level = 1'b1;
    logic [7:0] tx_byte       = '0;
    logic       tx_running    = 1'b0;
    logic [3:0] tx_slot       = TX_PHASE_START;
    logic [1:0] tx_ticks      = '0;
    logic       tx_line_level = 1'b1;

    t_tick_res   expected_ticks[$];
    int unsigned mismatches       = 0;
    int unsigned ticks_sent       = 0;
    int unsigned ticks_since_load = FRAME_TICKS;
    int unsigned stall_left       = 0;
    bit          quiet_in         = 1'b0;
    bit          quiet_out        = 1'b0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic t_tick_res predict_tick(input logic lvl, input logic start,
                                               input logic [7:0] data);
        t_tick_res r;
        r = '0;
        case (rx_phase)
            RX_CHECK: begin
                rx_ticks = rx_ticks + 2'd1;
                if (rx_ticks == SAMPLE_TICK) begin
                    if (lvl) begin
                        rx_phase = RX_IDLE;
                        r.rx.false_start = 1'b1;
                    end else begin
                        rx_phase     = RX_DATA;
                        rx_byte      = '0;
                        rx_bits_seen = '0;
                        rx_ticks     = '0;
                    end
                end
            end
            RX_DATA: begin
                rx_ticks = rx_ticks + 2'd1;
                if (rx_ticks == SAMPLE_TICK) begin
                    if (rx_bits_seen < DATA_BITS) begin
                        if (lvl) rx_byte[rx_bits_seen[2:0]] = 1'b1;
                        rx_bits_seen = rx_bits_seen + 4'd1;
                    end else begin
                        r.rx.valid = 1'b1;
                        r.rx.data  = rx_byte;
                        rx_phase   = RX_IDLE;
                    end
                end else if (rx_ticks >= TICKS_PER_BIT) begin
                    rx_ticks = '0;
                end
            end
            default: begin
                rx_phase = RX_IDLE;
                if (rx_prev_level && !lvl) begin
                    rx_phase = RX_CHECK;
                    rx_ticks = '0;
                end
            end
        endcase
        rx_prev_level = lvl;

        if (start) begin
            if (tx_running) begin
                r.tx.rejected = 1'b1;
            end else begin
                tx_byte    = data;
                tx_running = 1'b1;
                tx_slot    = TX_PHASE_START;
                tx_ticks   = '0;
            end
        end

        if (tx_running) begin
            tx_ticks = tx_ticks + 2'd1;
            if (tx_ticks >= TICKS_PER_BIT) begin
                tx_ticks = '0;
                if (tx_slot == TX_PHASE_START) begin
                    tx_line_level = 1'b0;
                    tx_slot       = TX_PHASE_START + 4'd1;
                end else if (tx_slot <= DATA_BITS) begin
                    tx_line_level = tx_byte[3'(tx_slot - 4'd1)];
                    tx_slot       = tx_slot + 4'd1;
                end else begin
                    tx_line_level = 1'b1;
                    tx_running    = 1'b0;
                end
            end
        end

        r.tx.level = tx_line_level;
        r.tx.busy  = tx_running;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] want,
                                   input logic [15:0] got);
        $display("%0t ns: mismatch on %s: expected %0h, got %0h", $time, what, want, got);
        mismatches++;
    endtask

    task automatic compare_field(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) report_mismatch(what, {8'h00, want}, {8'h00, got});
    endtask

    // check the oldest expectation first, then queue the new request's result
    always @(posedge i_clk) begin
        t_tick_res got_res;
        t_tick_res want_res;
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                got_res = {res_ch.tx_level, res_ch.tx_busy, res_ch.tx_rejected,
                           res_ch.rx_valid, res_ch.rx_data, res_ch.rx_false_start};
                if (expected_ticks.size() == 0) begin
                    report_mismatch("result with nothing pending", '0, 16'(got_res));
                end else begin
                    want_res = expected_ticks.pop_front();
                    compare_field("tx_level", 8'(want_res.tx.level), 8'(got_res.tx.level));
                    compare_field("tx_busy", 8'(want_res.tx.busy), 8'(got_res.tx.busy));
                    compare_field("tx_rejected", 8'(want_res.tx.rejected),
                                  8'(got_res.tx.rejected));
                    compare_field("rx_valid", 8'(want_res.rx.valid), 8'(got_res.rx.valid));
                    compare_field("rx_data", want_res.rx.data, got_res.rx.data);
                    compare_field("rx_false_start", 8'(want_res.rx.false_start),
                                  8'(got_res.rx.false_start));
                end
            end
            if (tick_ch.valid && tick_ch.ready) begin
                expected_ticks.push_back(predict_tick(tick_ch.rx_level, tick_ch.tx_start,
                                                      tick_ch.tx_data));
            end
        end
    end

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
            if (!quiet_out) stall_left = pick_gap();
        end
        if ($urandom_range(0, 299) == 0) quiet_in <= ~quiet_in;
        if ($urandom_range(0, 299) == 0) quiet_out <= ~quiet_out;
    end

    task automatic send_tick(input logic lvl, input logic start, input logic [7:0] data);
        int unsigned gap;
        gap = quiet_in ? 0 : pick_gap();
        if (gap > 0) begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        tick_ch.valid    <= 1'b1;
        tick_ch.rx_level <= lvl;
        tick_ch.tx_start <= start;
        tick_ch.tx_data  <= data;
        do @(posedge i_clk); while (!tick_ch.ready);
        ticks_sent++;
    endtask

    // request a load mostly when the transmitter should be idle, rarely while busy
    task automatic send_line_tick(input logic lvl);
        logic start;
        if (ticks_since_load >= FRAME_TICKS) start = ($urandom_range(0, 3) == 0);
        else if (ticks_since_load == FRAME_TICKS - 1) start = ($urandom_range(0, 4) == 0);
        else start = ($urandom_range(0, 49) == 0);
        if (start && ticks_since_load >= FRAME_TICKS) ticks_since_load = 0;
        else ticks_since_load++;
        send_tick(lvl, start, 8'($urandom_range(0, 255)));
    endtask

    task automatic test_idle_line();
        send_tick(1'b1, 1'b0, 8'h00);
        send_tick(1'b1, 1'b0, 8'hFF);
    endtask

    task automatic test_false_start();
        send_tick(1'b0, 1'b0, 8'h00);
        send_tick(1'b1, 1'b0, 8'h00);
        send_tick(1'b1, 1'b0, 8'h00);
    endtask

    // receive 0x00 while sending 0xFF; reject a load mid-frame and on the last tick
    task automatic test_duplex_frame();
        int   t;
        logic lvl;
        logic start;
        logic [7:0] data;
        for (t = 0; t < FRAME_TICKS; t++) begin
            lvl   = (t >= FRAME_TICKS - int'(TICKS_PER_BIT));
            start = (t == 0) || (t == 10) || (t == FRAME_TICKS - 1);
            data  = (t == 0) ? 8'hFF : (t == 10) ? 8'h00 : 8'h5A;
            send_tick(lvl, start, data);
        end
    endtask

    task automatic test_load_after_frame_end();
        send_tick(1'b1, 1'b1, 8'hA5);
        send_tick(1'b1, 1'b0, 8'h00);
    endtask

    task automatic test_random_traffic();
        int unsigned stop_at;
        int unsigned b;
        int unsigned k;
        logic [9:0]  frame_bits;
        stop_at          = ticks_sent + RANDOM_TICKS;
        ticks_since_load = 0;
        while (ticks_sent < stop_at) begin
            case ($urandom_range(0, 9))
                0: begin
                    repeat ($urandom_range(1, 8)) send_line_tick(1'($urandom_range(0, 1)));
                end
                1: begin
                    repeat ($urandom_range(1, 2)) send_line_tick(1'b0);
                    repeat (int'(TICKS_PER_BIT)) send_line_tick(1'b1);
                end
                default: begin
                    repeat ($urandom_range(0, 4)) send_line_tick(1'b1);
                    frame_bits = {($urandom_range(0, 7) != 0), 8'($urandom_range(0, 255)),
                                  1'b0};
                    for (b = 0; b < 10; b++) begin
                        for (k = 0; k < TICKS_PER_BIT; k++) send_line_tick(frame_bits[b]);
                    end
                end
            endcase
        end
    endtask

    initial begin
        tick_ch.valid    = 1'b0;
        tick_ch.rx_level = 1'b1;
        tick_ch.tx_start = 1'b0;
        tick_ch.tx_data  = 8'h00;
        res_ch.ready     = 1'b1;
        i_rst_n          = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_line();
        test_false_start();
        test_duplex_frame();
        test_load_after_frame_end();
        test_random_traffic();

        tick_ch.valid <= 1'b0;
        while (expected_ticks.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_uart_8n1_transceiver_3x passed");
        end else begin
            $display("tb_uart_8n1_transceiver_3x failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb_uart_8n1_transceiver_3x failed");
        $finish;
    end

endmodule
